>>> sv/mfe_pkg.sv
package mfe_pkg;

    localparam int FrameLen = 9;
    localparam int IdxW     = 4;
    localparam int ValW     = 16;
    localparam int ChkW     = 7;

    localparam logic [7:0]        HeaderByte = 8'hFF;
    localparam logic [IdxW-1:0]   LastIdx    = IdxW'(FrameLen - 1);

    // reciprocal division: an operand below the saturation limit fits AbsW bits
    localparam int AbsW   = 19;
    localparam int RecipW = 20;
    localparam int Shift  = 22;
    localparam int QW     = 15;

    localparam logic [RecipW-1:0] RecipTen  = 20'd419431;   // ceil(2^22 / 10)
    localparam logic [RecipW-1:0] RecipFive = 20'd838861;   // ceil(2^22 / 5)
    localparam logic [32:0]       LimitTen  = 33'd320010;   // 32001 * 10
    localparam logic [32:0]       LimitFive = 33'd160005;   // 32001 * 5
    localparam logic [QW-1:0]     SatMag    = 15'd32000;

    typedef logic [7:0] t_byte;

    // divide with truncation toward zero, clamp to +-32000, keep nonzero inputs nonzero
    function automatic logic [ValW-1:0] f_scale(
        input logic signed [31:0] mag,
        input logic [RecipW-1:0]  recip,
        input logic [32:0]        limit
    );
        logic [32:0]              abs_v;
        logic [AbsW+RecipW-1:0]   prod;
        logic [QW-1:0]            q;
        logic [ValW-1:0]          q_ext;
        abs_v = mag[31] ? 33'(-{mag[31], mag}) : {1'b0, mag};
        prod  = abs_v[AbsW-1:0] * recip;
        q     = prod[Shift+QW-1:Shift];
        if (abs_v >= limit) begin
            q = SatMag;
        end else if (q == '0 && mag != '0) begin
            q = QW'(1);
        end
        q_ext = {1'b0, q};
        return mag[31] ? ValW'(-q_ext) : q_ext;
    endfunction

endpackage

>>> sv/magnitude_frame_encoder.sv
// an accepted item waits in the input register until the serializer is free, then is scaled into
//   the frame register, which offers its header byte first and its checksum byte last
// the frame leaves one byte at a time through the output port; the input register takes the next
//   item while the current frame is still going out
// reset: synchronous, active low; clears the valid flags and the byte counter
module magnitude_frame_encoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_left_magnitude,
    input  logic signed [31:0]   i_right_magnitude,
    input  logic signed [31:0]   i_back_magnitude,
    output logic                 o_valid,
    input  logic                 i_stall,
    output mfe_pkg::t_byte       o_frame_byte,
    output logic                 o_last_byte
);
    import mfe_pkg::*;

    // input register
    logic               r_in_vld;
    logic signed [31:0] r_left;
    logic signed [31:0] r_right;
    logic signed [31:0] r_back;

    // frame register and byte counter
    logic               r_out_vld;
    logic [ValW-1:0]    r_left_val;
    logic [ValW-1:0]    r_right_val;
    logic [ValW-1:0]    r_back_val;
    logic [ChkW-1:0]    r_chk;
    logic [IdxW-1:0]    r_idx;

    logic [ValW-1:0]    n_left_val;
    logic [ValW-1:0]    n_right_val;
    logic [ValW-1:0]    n_back_val;
    logic [7:0]         n_sum;

    logic               in_take;
    logic               out_take;
    logic               frame_done;
    logic               load_frame;
    t_byte              frame_bytes [FrameLen];

    // handshakes
    assign out_take   = r_out_vld && !i_stall;
    assign frame_done = out_take && (r_idx == LastIdx);
    // the frame register frees up when empty or when its checksum byte leaves
    assign load_frame = r_in_vld && (!r_out_vld || frame_done);
    // the input register stalls only while it holds an item that cannot move on
    assign o_stall    = r_in_vld && !load_frame;
    assign in_take    = i_valid && !o_stall;

    // scaling: one reciprocal multiply per field plus clamp
    always_comb begin
        n_left_val  = f_scale(r_left,  RecipTen,  LimitTen);
        n_right_val = f_scale(r_right, RecipTen,  LimitTen);
        n_back_val  = f_scale(r_back,  RecipFive, LimitFive);
        // the two header bytes add up to 0xFE modulo 256
        n_sum = 8'hFE
              + n_left_val[7:0]  + n_left_val[15:8]
              + n_right_val[7:0] + n_right_val[15:8]
              + n_back_val[7:0]  + n_back_val[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (load_frame) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_left  <= i_left_magnitude;
            r_right <= i_right_magnitude;
            r_back  <= i_back_magnitude;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else if (load_frame) begin
            r_out_vld <= 1'b1;
            r_idx     <= '0;
        end else if (frame_done) begin
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else if (out_take) begin
            r_idx     <= r_idx + IdxW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_frame) begin
            r_left_val  <= n_left_val;
            r_right_val <= n_right_val;
            r_back_val  <= n_back_val;
            r_chk       <= n_sum[ChkW-1:0];
        end
    end

    // frame layout in transmission order: header, header, values low byte first, checksum
    assign frame_bytes[0] = HeaderByte;
    assign frame_bytes[1] = HeaderByte;
    assign frame_bytes[2] = r_left_val[7:0];
    assign frame_bytes[3] = r_left_val[15:8];
    assign frame_bytes[4] = r_right_val[7:0];
    assign frame_bytes[5] = r_right_val[15:8];
    assign frame_bytes[6] = r_back_val[7:0];
    assign frame_bytes[7] = r_back_val[15:8];
    assign frame_bytes[8] = {1'b0, r_chk};

    assign o_valid      = r_out_vld;
    assign o_frame_byte = frame_bytes[r_idx];
    assign o_last_byte  = (r_idx == LastIdx);

    // byte counter never runs past the checksum position
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_idx <= LastIdx)
        else $error("byte counter out of range");

    // checksum byte always has its top bit clear
    a_chk_msb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_byte) |-> !o_frame_byte[7])
        else $error("checksum byte has top bit set");

    // a freshly loaded frame starts with a header byte
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_frame |=> (o_valid && o_frame_byte == HeaderByte && !o_last_byte))
        else $error("frame does not start with header");

    // with nothing queued, the end of a frame empties the output
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (frame_done && !r_in_vld) |=> !o_valid)
        else $error("output valid after last frame");

endmodule

>>> verif/mfe_frame_checker.sv
`timescale 1ns / 100ps

module mfe_frame_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic signed [31:0]   i_left_magnitude,
    input  logic signed [31:0]   i_right_magnitude,
    input  logic signed [31:0]   i_back_magnitude,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  mfe_pkg::t_byte       i_frame_byte,
    input  logic                 i_last_byte,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        mfe_pkg::t_byte frame_byte;
        logic           last_byte;
    } t_frame_entry;

    t_frame_entry frame_byte_q[$];
    int           fail_count = 0;
    int           byte_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = frame_byte_q.size();

    // signed divide toward zero, clamp, keep nonzero inputs nonzero
    function automatic logic [15:0] scale_coil(logic signed [31:0] mag, int divisor);
        longint m;
        longint q;
        m = mag;
        q = m / divisor;
        if (q > 32000) begin
            q = 32000;
        end else if (q < -32000) begin
            q = -32000;
        end
        if (q == 0 && m != 0) begin
            q = (m > 0) ? 1 : -1;
        end
        return q[15:0];
    endfunction

    // build the nine bytes of one frame and queue them
    task automatic encode_frame(logic signed [31:0] left, logic signed [31:0] right,
                                logic signed [31:0] back);
        logic [15:0]    vals[3];
        mfe_pkg::t_byte bytes[9];
        mfe_pkg::t_byte sum;
        t_frame_entry   ent;
        vals[0]  = scale_coil(left, 10);
        vals[1]  = scale_coil(right, 10);
        vals[2]  = scale_coil(back, 5);
        bytes[0] = mfe_pkg::HeaderByte;
        bytes[1] = mfe_pkg::HeaderByte;
        for (int i = 0; i < 3; i++) begin
            bytes[2 + 2 * i] = vals[i][7:0];
            bytes[3 + 2 * i] = vals[i][15:8];
        end
        sum = '0;
        for (int i = 0; i < 8; i++) begin
            sum = sum + bytes[i];
        end
        bytes[8] = sum & 8'h7F;
        for (int i = 0; i < 9; i++) begin
            ent.frame_byte = bytes[i];
            ent.last_byte  = (i == 8);
            frame_byte_q.push_back(ent);
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("byte %0d: %s got 0x%0h want 0x%0h", byte_count, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_frame_entry want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                encode_frame(i_left_magnitude, i_right_magnitude, i_back_magnitude);
            end
            if (i_out_valid && !i_out_stall) begin
                if (frame_byte_q.size() == 0) begin
                    report_mismatch("unexpected byte", i_frame_byte, 0);
                end else begin
                    want = frame_byte_q.pop_front();
                    if (i_frame_byte !== want.frame_byte) begin
                        report_mismatch("frame_byte", i_frame_byte, want.frame_byte);
                    end
                    if (i_last_byte !== want.last_byte) begin
                        report_mismatch("last_byte", i_last_byte, want.last_byte);
                    end
                end
                byte_count++;
            end
        end
    end

endmodule

>>> verif/magnitude_frame_encoder_tb.sv
`timescale 1ns / 100ps

module magnitude_frame_encoder_tb;

    localparam int RandomItems = 310;
    localparam int QuietItems  = 40;    // tail of the run with no idling at all
    localparam int DrainWait   = 20;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [31:0]   left_mag = '0;
    logic signed [31:0]   right_mag = '0;
    logic signed [31:0]   back_mag = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    mfe_pkg::t_byte       frame_byte;
    logic                 last_byte;
    int                   fail_count;
    int                   pending;
    logic                 quiet = 1'b0;

    always #5 i_clk = ~i_clk;

    magnitude_frame_encoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (in_valid),
        .o_stall           (in_stall),
        .i_left_magnitude  (left_mag),
        .i_right_magnitude (right_mag),
        .i_back_magnitude  (back_mag),
        .o_valid           (out_valid),
        .i_stall           (out_stall),
        .o_frame_byte      (frame_byte),
        .o_last_byte       (last_byte)
    );

    // watches both channels, predicts every frame and compares byte by byte
    mfe_frame_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_left_magnitude  (left_mag),
        .i_right_magnitude (right_mag),
        .i_back_magnitude  (back_mag),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_frame_byte      (frame_byte),
        .i_last_byte       (last_byte),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // present one item at a falling edge and hold it until accepted
    task automatic send_item(logic signed [31:0] left, logic signed [31:0] right,
                             logic signed [31:0] back);
        bit accepted;
        @(negedge i_clk);
        in_valid  <= 1'b1;
        left_mag  <= left;
        right_mag <= right;
        back_mag  <= back;
        accepted  = 1'b0;
        while (!accepted) begin
            @(posedge i_clk);
            accepted = !in_stall;
        end
    endtask

    // sender idles for a random burst, now and then
    task automatic maybe_gap();
        int n;
        if (!quiet && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 14);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // sender holds off until every queued frame byte has come out
    task automatic hold_until_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // random magnitude, biased toward the interesting regions for this divisor
    function automatic logic signed [31:0] pick_magnitude(int divisor);
        int kind;
        int lim;
        int v;
        kind = $urandom_range(0, 9);
        lim  = 32001 * divisor;
        case (kind)
            0, 1: begin
                v = $urandom;
            end
            2, 3: begin
                // around zero: quotient zero turns into plus or minus one
                v = int'($urandom_range(0, 4 * divisor)) - 2 * divisor;
            end
            4: begin
                // around the saturation threshold, either sign
                v = lim + int'($urandom_range(0, 20)) - 10;
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            5: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            default: begin
                v = int'($urandom_range(0, 2 * lim + 2 * divisor)) - lim - divisor;
            end
        endcase
        return v;
    endfunction

    // receiver stalls in random bursts, with open stretches between them
    initial begin
        int n;
        forever begin
            if (quiet) begin
                @(negedge i_clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 14);
                @(negedge i_clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                n = $urandom_range(1, 20);
                @(negedge i_clk);
                out_stall <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, smallest nonzero, rounding boundaries
        send_item(0, 0, 0);
        send_item(1, -1, 1);
        send_item(-1, 1, -1);
        send_item(9, -9, 4);
        send_item(10, -10, 5);
        send_item(-10, 10, -5);
        send_item(19, -19, 9);
        // saturation threshold on both sides
        send_item(320009, -320009, 160004);
        send_item(320010, -320010, 160005);
        send_item(-320010, 320010, -160005);
        send_item(319999, -319999, 159999);
        // field extremes, most negative divides like any other value
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_item(32'sh7FFF_FFFF, 0, 32'sh8000_0000);
        // data bytes equal to the header byte, no escaping
        send_item(-10, -10, -5);
        send_item(-2550, -2560, -1275);
        send_item(2550, 2550, 1275);
        // checksum with a carry out of the low byte
        send_item(-2570, -2570, -1285);
        send_item(12345, -54321, 77777);

        hold_until_drained();

        for (int i = 0; i < RandomItems; i++) begin
            if (i == RandomItems - QuietItems) begin
                quiet = 1'b1;
            end
            if (i == RandomItems / 2) begin
                hold_until_drained();
            end
            send_item(pick_magnitude(10), pick_magnitude(10), pick_magnitude(5));
            maybe_gap();
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        // any byte beyond the last frame counts as unexpected
        repeat (DrainWait) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("magnitude_frame_encoder: match");
        end else begin
            $display("magnitude_frame_encoder: mismatch");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("magnitude_frame_encoder: mismatch");
        $finish;
    end

endmodule
